FILE: sv/dtvb_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the depth-tested visibility buffer.
// No dependencies.
package dtvb_pkg;

  localparam int COORD_W   = 16;
  localparam int DEPTH_W   = 24;
  localparam int ID_W      = 32;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 4;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE = '1;
  localparam logic [ID_W-1:0]    ID_NONE   = '1;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 4'd1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

FILE: sv/depth_tested_visibility_buffer.sv
// Depth-tested visibility buffer: per-pixel depth and object id stores.
// Item channel (item_valid/item_stall) takes action, pixel_x, pixel_y,
// new_depth and object_id; result channel (result_valid/result_stall) returns
// read_id, read_depth, in_range and write_passed, one word per item, in order.
// A write replaces a pixel only when in range and new_depth is strictly less
// than the stored depth; a query returns the pixel; a clear resets all pixels.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets active_width
// (index 0) and active_height (index 1); write it only while idle.
// s1 holds each item until the result register is free and no sweep runs.
// Throughput: one word per cycle for writes and queries while result_stall is
// low; the depth and id RAMs are read on acceptance and written back as the
// word leaves s1, with a one-entry bypass for back-to-back same-pixel hits.
// Reset and each clear sweep all MAX_WIDTH * MAX_HEIGHT entries (16384 at
// defaults) writing 1.0 / all-ones; item_stall stays high during the sweep.
// A held result_stall backs up through one pipeline stage to item_stall.
`timescale 1ns / 1ps
// Top level; depends on dtvb_pkg, dtvb_ram and dtvb_index.
module depth_tested_visibility_buffer #(
  parameter int MAX_WIDTH  = dtvb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dtvb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [1:0]                     action,
  input  logic [dtvb_pkg::COORD_W-1:0]   pixel_x,
  input  logic [dtvb_pkg::COORD_W-1:0]   pixel_y,
  input  logic [dtvb_pkg::DEPTH_W-1:0]   new_depth,
  input  logic [dtvb_pkg::ID_W-1:0]      object_id,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [dtvb_pkg::ID_W-1:0]      read_id,
  output logic [dtvb_pkg::DEPTH_W-1:0]   read_depth,
  output logic                           in_range,
  output logic                           write_passed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dtvb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtvb_pkg::CFG_W-1:0]     cfg_data
);
  import dtvb_pkg::*;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = addr_bits(STORE_SIZE);
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_SIZE - 1);

  logic [CFG_W-1:0] active_width;
  logic [CFG_W-1:0] active_height;

  state_t            state;
  logic [ADDR_W-1:0] sweep_addr;
  logic              sweeping;

  logic              accept;
  logic              idx_inside;
  logic [ADDR_W-1:0] idx_addr;

  logic               s1_valid;
  logic [1:0]         s1_action;
  logic               s1_inside;
  logic [ADDR_W-1:0]  s1_addr;
  logic [DEPTH_W-1:0] s1_depth;
  logic [ID_W-1:0]    s1_id;
  logic               s1_adv;

  logic               byp_valid;
  logic [ADDR_W-1:0]  byp_addr;
  logic [DEPTH_W-1:0] byp_depth;
  logic [ID_W-1:0]    byp_id;

  logic [DEPTH_W-1:0] ram_depth;
  logic [ID_W-1:0]    ram_id;
  logic [DEPTH_W-1:0] cur_depth;
  logic [ID_W-1:0]    cur_id;
  logic               passed;
  logic               out_free;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DEPTH_W-1:0] mem_wdepth;
  logic [ID_W-1:0]    mem_wid;

  logic [ID_W-1:0]    res_id;
  logic [DEPTH_W-1:0] res_depth;
  logic               res_inr;
  logic               res_pass;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= ACTIVE_RESET;
      active_height <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACTIVE_WIDTH:  active_width  <= cfg_data;
        REG_ACTIVE_HEIGHT: active_height <= cfg_data;
        default: ;
      endcase
    end
  end

  dtvb_index #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_index (
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .active_width  (active_width),
    .active_height (active_height),
    .in_extent     (idx_inside),
    .addr          (idx_addr)
  );

  assign sweeping   = (state == ST_SWEEP);
  assign out_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && (state == ST_RUN) && out_free;
  assign item_stall = sweeping || (s1_valid && !s1_adv);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (sweep_addr == SWEEP_LAST) begin
        state <= ST_RUN;
      end
    end else if (accept && action == ACT_CLEAR) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_inside <= idx_inside;
      s1_addr   <= idx_addr;
      s1_depth  <= new_depth;
      s1_id     <= object_id;
    end
  end

  // forward the last write-back when the next word hits the same pixel
  always_comb begin
    if (byp_valid && byp_addr == s1_addr) begin
      cur_depth = byp_depth;
      cur_id    = byp_id;
    end else begin
      cur_depth = ram_depth;
      cur_id    = ram_id;
    end
    passed = (s1_action == ACT_WRITE) && s1_inside && (s1_depth < cur_depth);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (accept && action == ACT_CLEAR) begin
      byp_valid <= 1'b0;
    end else if (s1_adv) begin
      byp_valid <= passed;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      byp_addr  <= s1_addr;
      byp_depth <= s1_depth;
      byp_id    <= s1_id;
    end
  end

  always_comb begin
    mem_we     = sweeping || (s1_adv && passed);
    mem_waddr  = sweeping ? sweep_addr : s1_addr;
    mem_wdepth = sweeping ? DEPTH_ONE : s1_depth;
    mem_wid    = sweeping ? ID_NONE : s1_id;
  end

  dtvb_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (STORE_SIZE)
  ) u_depth_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdepth),
    .re    (accept),
    .raddr (idx_addr),
    .rdata (ram_depth)
  );

  dtvb_ram #(
    .WIDTH (ID_W),
    .DEPTH (STORE_SIZE)
  ) u_id_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wid),
    .re    (accept),
    .raddr (idx_addr),
    .rdata (ram_id)
  );

  always_comb begin
    res_id    = ID_NONE;
    res_depth = DEPTH_ONE;
    res_inr   = 1'b0;
    res_pass  = 1'b0;
    case (s1_action)
      ACT_WRITE, ACT_QUERY: begin
        if (s1_inside) begin
          res_id    = passed ? s1_id : cur_id;
          res_depth = passed ? s1_depth : cur_depth;
          res_inr   = 1'b1;
          res_pass  = passed;
        end
      end
      ACT_CLEAR: ;
      default: begin
        res_id    = '0;
        res_depth = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_id      <= res_id;
      read_depth   <= res_depth;
      in_range     <= res_inr;
      write_passed <= res_pass;
    end
  end

`ifndef NO_ASSERTIONS
  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("advanced word did not reach the result register");

  a_pass_in_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && write_passed) |-> in_range)
    else $error("passing write reported out of range");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (sweeping && sweep_addr == SWEEP_LAST) |=> (state == ST_RUN))
    else $error("sweep did not return to run");

  a_no_bypass_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !byp_valid)
    else $error("bypass live during clear sweep");
`endif

endmodule

FILE: sv/dtvb_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on dtvb_pkg for address width sizing.
module dtvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = dtvb_pkg::addr_bits(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import dtvb_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dtvb_index.sv
`timescale 1ns / 1ps
// Pixel address unit: clamps the active extent, range-checks a coordinate and
// forms the linear store address y * width + x. Depends on dtvb_pkg.
module dtvb_index #(
  parameter int MAX_WIDTH  = dtvb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dtvb_pkg::DEF_MAX_HEIGHT,
  localparam int ADDR_W = dtvb_pkg::addr_bits(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic [dtvb_pkg::COORD_W-1:0] pixel_x,
  input  logic [dtvb_pkg::COORD_W-1:0] pixel_y,
  input  logic [dtvb_pkg::CFG_W-1:0]   active_width,
  input  logic [dtvb_pkg::CFG_W-1:0]   active_height,
  output logic                         in_extent,
  output logic [ADDR_W-1:0]            addr
);
  import dtvb_pkg::*;

  logic [CFG_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;
  logic [15:0]      prod;
  logic [15:0]      lin;

  always_comb begin
    eff_w  = (32'(active_width) < 32'(MAX_WIDTH)) ? active_width : CFG_W'(MAX_WIDTH);
    eff_h  = (32'(active_height) < 32'(MAX_HEIGHT)) ? active_height : CFG_W'(MAX_HEIGHT);
    in_extent = (pixel_x < COORD_W'(eff_w)) && (pixel_y < COORD_W'(eff_h));
    // in_extent implies both coordinates fit in 8 bits
    prod   = 16'(pixel_y[7:0]) * 16'(eff_w);
    lin    = prod + 16'(pixel_x[7:0]);
    addr   = ADDR_W'(lin);
  end

endmodule

FILE: bench/dtvb_check.sv
`timescale 1ns / 1ps
// Scoreboard for the depth-tested visibility buffer: tracks the pixel stores and
// extent registers, predicts each result word and compares it. Depends on dtvb_pkg.
module dtvb_check #(
  parameter int MAX_WIDTH  = dtvb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dtvb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  logic [1:0]                     action,
  input  logic [dtvb_pkg::COORD_W-1:0]   pixel_x,
  input  logic [dtvb_pkg::COORD_W-1:0]   pixel_y,
  input  logic [dtvb_pkg::DEPTH_W-1:0]   new_depth,
  input  logic [dtvb_pkg::ID_W-1:0]      object_id,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  logic [dtvb_pkg::ID_W-1:0]      read_id,
  input  logic [dtvb_pkg::DEPTH_W-1:0]   read_depth,
  input  logic                           in_range,
  input  logic                           write_passed,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dtvb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtvb_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import dtvb_pkg::*;

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DEPTH_W-1:0] depth;
    logic               hit;
    logic               passed;
  } pixel_word_t;

  logic [DEPTH_W-1:0] zdepth [PIXELS];
  logic [ID_W-1:0]    zid    [PIXELS];
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  pixel_word_t        expected_pixels [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic void wipe_stores();
    for (int i = 0; i < PIXELS; i++) begin
      zdepth[i] = DEPTH_ONE;
      zid[i]    = ID_NONE;
    end
  endfunction

  function automatic pixel_word_t resolve_access(input logic [1:0] act,
                                                 input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y,
                                                 input logic [DEPTH_W-1:0] d,
                                                 input logic [ID_W-1:0] oid);
    pixel_word_t r;
    int unsigned w;
    int unsigned h;
    int unsigned at;
    w = (width_reg < MAX_WIDTH) ? width_reg : MAX_WIDTH;
    h = (height_reg < MAX_HEIGHT) ? height_reg : MAX_HEIGHT;
    r = '{ID_NONE, DEPTH_ONE, 1'b0, 1'b0};
    case (act)
      ACT_CLEAR: wipe_stores();
      ACT_WRITE, ACT_QUERY: begin
        if (x < w && y < h) begin
          at = y * w + x;
          r.hit = 1'b1;
          if (act == ACT_WRITE && d < zdepth[at]) begin
            zdepth[at] = d;
            zid[at]    = oid;
            r.passed   = 1'b1;
          end
          r.id    = zid[at];
          r.depth = zdepth[at];
        end
      end
      default: r = '{'0, '0, 1'b0, 1'b0};
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_word_t want;
    if (rst) begin
      width_reg  = ACTIVE_RESET;
      height_reg = ACTIVE_RESET;
      wipe_stores();
      expected_pixels.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected word", read_id, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (read_id !== want.id) report_mismatch("read_id", read_id, want.id);
          if (read_depth !== want.depth)
            report_mismatch("read_depth", read_depth, want.depth);
          if (in_range !== want.hit) report_mismatch("in_range", in_range, want.hit);
          if (write_passed !== want.passed)
            report_mismatch("write_passed", write_passed, want.passed);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_WIDTH:  width_reg  = cfg_data;
          REG_ACTIVE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        expected_pixels.push_back(resolve_access(action, pixel_x, pixel_y, new_depth,
                                                 object_id));
    end
    outstanding <= expected_pixels.size();
  end

endmodule

FILE: bench/tb_depth_tested_visibility_buffer.sv
`timescale 1ns / 1ps
// Testbench top for the depth-tested visibility buffer: clock, reset, directed and
// random pixel traffic, extent changes, verdict. Depends on dtvb_pkg, dtvb_check, DUT.
module tb_depth_tested_visibility_buffer;
  import dtvb_pkg::*;

  localparam logic [1:0]           ACT_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 4'd15;
  localparam int                   STALL_LIMIT   = 100000;
  localparam int                   RANDOM_PER_PH = 75;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [1:0]           action = ACT_QUERY;
  logic [COORD_W-1:0]   pixel_x = '0;
  logic [COORD_W-1:0]   pixel_y = '0;
  logic [DEPTH_W-1:0]   new_depth = '0;
  logic [ID_W-1:0]      object_id = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [ID_W-1:0]      read_id;
  logic [DEPTH_W-1:0]   read_depth;
  logic                 in_range;
  logic                 write_passed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   outstanding;

  bit                   calm = 1'b0;
  int unsigned          aim_w = DEF_MAX_WIDTH;
  int unsigned          aim_h = DEF_MAX_HEIGHT;
  logic [COORD_W-1:0]   last_x = '0;
  logic [COORD_W-1:0]   last_y = '0;
  int                   quiet_cycles = 0;

  depth_tested_visibility_buffer u_top (.*);
  dtvb_check u_check (.*);

  always #5 clk = ~clk;

  always @(negedge clk) result_stall <= !calm && ($urandom_range(0, 99) < 32);

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_depth_tested_visibility_buffer failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [DEPTH_W-1:0] d,
                           input logic [ID_W-1:0] oid);
    while (!calm && $urandom_range(0, 99) < 32) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    pixel_x    <= x;
    pixel_y    <= y;
    new_depth  <= d;
    object_id  <= oid;
    last_x = x;
    last_y = y;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // all words back, pipeline flushed, any clear sweep finished
  task automatic drain();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (item_stall) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_extent(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input bit spare);
    drain();
    write_reg(REG_ACTIVE_WIDTH, w);
    write_reg(REG_ACTIVE_HEIGHT, h);
    if (spare) write_reg(REG_SPARE, 8'h5A);
    cfg_valid <= 1'b0;
    aim_w = (w == 0) ? 4 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
    aim_h = (h == 0) ? 4 : (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
  endtask

  task automatic random_item();
    int unsigned        pick;
    logic [1:0]         act;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DEPTH_W-1:0] d;
    pick = $urandom_range(0, 999);
    act = (pick < 600) ? ACT_WRITE : (pick < 955) ? ACT_QUERY :
          (pick < 995) ? ACT_SPARE : ACT_CLEAR;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // a few hot pixels so writes and queries keep landing on the same entries
      case ($urandom_range(0, 2))
        0: x = 0;
        1: x = COORD_W'(aim_w - 1);
        default: x = COORD_W'(aim_w / 2);
      endcase
      case ($urandom_range(0, 2))
        0: y = 0;
        1: y = COORD_W'(aim_h - 1);
        default: y = COORD_W'(aim_h / 2);
      endcase
    end else if (pick < 85) begin
      x = COORD_W'($urandom_range(0, aim_w - 1));
      y = COORD_W'($urandom_range(0, aim_h - 1));
    end else if (pick < 93) begin
      x = COORD_W'(aim_w + $urandom_range(0, 2));
      y = COORD_W'($urandom_range(0, aim_h + 1));
      if ($urandom_range(0, 1)) begin
        x = COORD_W'($urandom_range(0, aim_w - 1));
        y = COORD_W'(aim_h + $urandom_range(0, 2));
      end
    end else begin
      x = COORD_W'($urandom());
      y = COORD_W'($urandom());
    end
    if (act == ACT_QUERY && $urandom_range(0, 1)) begin
      x = last_x;
      y = last_y;
    end
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = 24'd1;
      2: d = 24'h800000;
      3: d = DEPTH_ONE - 1;
      4: d = DEPTH_ONE;
      5, 6: d = DEPTH_W'($urandom_range(0, 1000));
      default: d = DEPTH_W'($urandom());
    endcase
    send_item(act, x, y, d, $urandom());
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input bit quiet, input bit spare);
    set_extent(w, h, spare);
    calm = quiet;
    repeat (RANDOM_PER_PH) random_item();
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: default 128 x 128 extent
    send_item(ACT_QUERY, 0, 0, '0, '0);
    send_item(ACT_WRITE, 0, 0, 24'h800000, 32'h1234_5678);
    send_item(ACT_WRITE, 0, 0, 24'h800000, 32'hDEAD_BEEF);
    send_item(ACT_WRITE, 0, 0, 24'h800001, 32'hDEAD_BEEF);
    send_item(ACT_WRITE, 0, 0, '0, '0);
    send_item(ACT_QUERY, 0, 0, DEPTH_ONE, ID_NONE);
    send_item(ACT_WRITE, 127, 127, DEPTH_ONE, 32'h0000_0001);
    send_item(ACT_WRITE, 127, 127, DEPTH_ONE - 1, 32'hFFFF_FFFE);
    send_item(ACT_QUERY, 127, 127, '0, '0);
    send_item(ACT_WRITE, 128, 0, '0, 32'h0BAD_0BAD);
    send_item(ACT_WRITE, 0, 128, '0, 32'h0BAD_0BAD);
    send_item(ACT_QUERY, 16'hFFFF, 16'hFFFF, '0, '0);
    send_item(ACT_WRITE, 16'hFFFF, 0, '0, ID_NONE);
    send_item(ACT_SPARE, 5, 5, DEPTH_ONE, ID_NONE);
    send_item(ACT_WRITE, 5, 5, DEPTH_ONE - 1, ID_NONE);
    send_item(ACT_WRITE, 5, 5, 24'h555555, 32'h5555_5555);
    send_item(ACT_WRITE, 5, 5, 24'h2AAAAA, 32'hAAAA_AAAA);
    send_item(ACT_QUERY, 5, 5, '0, '0);
    send_item(ACT_WRITE, 127, 0, 24'h000100, 32'h7F00_0000);
    send_item(ACT_WRITE, 0, 127, 24'h000200, 32'h007F_0000);
    send_item(ACT_CLEAR, 5, 5, '0, '0);
    send_item(ACT_QUERY, 5, 5, '0, '0);
    send_item(ACT_QUERY, 0, 0, '0, '0);

    run_phase(8'd128, 8'd128, 1'b0, 1'b0);
    run_phase(8'd1, 8'd128, 1'b0, 1'b1);
    run_phase(8'd37, 8'd5, 1'b1, 1'b0);
    run_phase(8'd255, 8'd1, 1'b0, 1'b0);
    run_phase(8'd0, 8'd0, 1'b0, 1'b0);
    run_phase(8'd200, 8'd255, 1'b0, 1'b0);

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_depth_tested_visibility_buffer passed");
    end else begin
      $display("tb_depth_tested_visibility_buffer failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/dtvb_pkg.sv
sv/dtvb_ram.sv
sv/dtvb_index.sv
sv/depth_tested_visibility_buffer.sv
bench/dtvb_check.sv
bench/tb_depth_tested_visibility_buffer.sv
